>>> rtl/bgc_pkg.sv
`timescale 1ns / 1ps

package bgc_pkg;

    // width of the wrapping millisecond timer; all time math wraps at this width
    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 2;
    // pin level plus timestamp, padded to whole bytes
    localparam int IN_BITS   = ((TIME_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_BITS  = 8;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CFG_BITS-1:0]  t_cfg;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_WAIT     = 2'd1,
        REG_SHORT    = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        EV_NONE   = 4'd0,
        EV_SINGLE = 4'd1,
        EV_DOUBLE = 4'd2,
        EV_TRIPLE = 4'd3,
        EV_LONG1  = 4'd4,
        EV_LONG2  = 4'd5,
        EV_LONG3  = 4'd6,
        EV_OTHER  = 4'd7,
        EV_HOLD   = 4'd8
    } t_event;

    // extend the running pattern by one press of the given kind
    function automatic t_event next_pattern(input t_event ev, input logic is_short);
        t_event res;
        res = EV_OTHER;
        if (is_short) begin
            if (ev == EV_NONE)        res = EV_SINGLE;
            else if (ev == EV_SINGLE) res = EV_DOUBLE;
            else if (ev == EV_DOUBLE) res = EV_TRIPLE;
        end else begin
            if (ev == EV_NONE)        res = EV_LONG1;
            else if (ev == EV_LONG1)  res = EV_LONG2;
            else if (ev == EV_LONG2)  res = EV_LONG3;
        end
        return res;
    endfunction

endpackage

>>> rtl/button_gesture_classifier.sv
`timescale 1ns / 1ps

// Button gesture classifier. Each input word is one poll of an active-low push
// button: the raw pin level and a free-running millisecond timestamp that wraps
// at 2^32. Edges are debounced by a lockout of debounce_ms since the last
// accepted edge. Released presses are classed short (duration <= short_press_ms)
// or long, and successive presses build single/double/triple click or long-press
// patterns (anything else becomes "other"). A press held longer than wait_ms
// reports hold on every poll, and its release reports nothing and drops the
// pattern. Once more than wait_ms has passed since the last release the pattern
// is reported once. Timestamp 0 is the "no press / nothing pending" marker, so a
// press starting exactly at time 0 is ignored for classification. Every input
// word yields exactly one output word carrying the debounced state and the event
// code. Results are registered in the output register, or in the skid entry while it
// stalls; one word is taken per cycle while input ready is high. The whole update is
// a few parallel 32-bit subtract/compares feeding the state registers. This two-entry
// output stage keeps input ready high while one result waits. Configuration must be
// written through the plain write port only while no word is in flight, unchecked by the block.
module button_gesture_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [bgc_pkg::IDX_BITS-1:0] i_cfg_addr,
    input  logic [bgc_pkg::CFG_BITS-1:0] i_cfg_wdata,
    // input words
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [bgc_pkg::IN_BITS-1:0]  i_s_axis_tdata,  // [0] pin_level, [32:1] now_ms
    // result words
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [bgc_pkg::OUT_BITS-1:0] o_m_axis_tdata   // [0] is_pressed, [4:1] event_code
);
    import bgc_pkg::*;

    // configuration registers
    t_cfg   r_debounce;
    t_cfg   r_wait;
    t_cfg   r_short;

    // classifier state
    logic   r_pressed,    n_pressed;
    t_time  r_last_edge,  n_last_edge;
    t_time  r_press_start, n_press_start;
    t_time  r_trigger,    n_trigger;
    t_event r_pending,    n_pending;

    // output stage
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;
    logic                r_skid_valid;
    logic [OUT_BITS-1:0] r_skid_data;

    logic   in_accept;
    logic   out_take;
    logic   level_high;
    t_time  now;
    t_time  el_edge;
    t_time  el_press;
    t_time  el_trig;
    logic   edge_ok;
    logic   rel_edge;
    logic   press_edge;
    logic   released;
    logic   hold_now;
    t_event ev_out;
    logic [OUT_BITS-1:0] res_data;

    assign o_s_axis_tready = !r_skid_valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take        = r_out_valid && i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign level_high = i_s_axis_tdata[0];
    assign now        = i_s_axis_tdata[TIME_BITS:1];

    // wrapping elapsed times, all in parallel
    assign el_edge  = now - r_last_edge;
    assign el_press = now - r_press_start;
    assign el_trig  = now - r_trigger;

    assign edge_ok    = el_edge > t_time'(r_debounce);
    assign rel_edge   = r_pressed && level_high && edge_ok;
    assign press_edge = !r_pressed && !level_high && edge_ok;
    // a release only ends a press that has a valid start time
    assign released   = rel_edge && (r_press_start != '0);
    // hold: still pressed with no edge this poll and held past wait_ms
    assign hold_now   = !rel_edge && !press_edge && (r_press_start != '0)
                        && (el_press > t_time'(r_wait));

    always_comb begin
        n_pressed     = r_pressed;
        n_last_edge   = r_last_edge;
        n_press_start = r_press_start;
        n_trigger     = r_trigger;
        n_pending     = r_pending;
        ev_out        = EV_NONE;

        if (rel_edge) begin
            n_pressed     = 1'b0;
            n_last_edge   = now;
            n_press_start = '0;
        end else if (press_edge) begin
            n_pressed     = 1'b1;
            n_last_edge   = now;
            n_press_start = now;
        end

        priority if (hold_now) begin
            n_pending = EV_HOLD;
            ev_out    = EV_HOLD;
        end else if (released) begin
            if (r_pending == EV_HOLD) begin
                // release after a hold drops the pattern
                n_pending = EV_NONE;
                n_trigger = '0;
            end else begin
                // trigger restarts now, so no idle report this poll
                n_trigger = now;
                n_pending = next_pattern(r_pending, el_press <= t_time'(r_short));
            end
        end else if ((r_trigger != '0) && (el_trig > t_time'(r_wait))) begin
            // idle long enough since last release: report the pattern
            ev_out    = r_pending;
            n_pending = EV_NONE;
            n_trigger = '0;
        end
    end

    assign res_data = {3'b000, ev_out, n_pressed};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= t_cfg'(50);
            r_wait     <= t_cfg'(500);
            r_short    <= t_cfg'(300);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DEBOUNCE: r_debounce <= i_cfg_wdata;
                REG_WAIT:     r_wait     <= i_cfg_wdata;
                REG_SHORT:    r_short    <= i_cfg_wdata;
                default: ;  // unused index, ignored
            endcase
        end
    end

    // classifier state, updated once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed     <= 1'b0;
            r_last_edge   <= '0;
            r_press_start <= '0;
            r_trigger     <= '0;
            r_pending     <= EV_NONE;
        end else if (in_accept) begin
            r_pressed     <= n_pressed;
            r_last_edge   <= n_last_edge;
            r_press_start <= n_press_start;
            r_trigger     <= n_trigger;
            r_pending     <= n_pending;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_accept) begin
                r_out_data <= res_data;
            end
        end else if (in_accept) begin
            r_skid_data <= res_data;
        end
    end

endmodule

>>> rtl/bgc_checker.sv
`timescale 1ns / 1ps

module bgc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [bgc_pkg::OUT_BITS-1:0] o_m_axis_tdata
);
    import bgc_pkg::*;

    // output stays empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // with the output empty the skid is empty too, so input is ready
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input not ready while output empty");

    // event codes stay within the defined set
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[4:1] <= EV_HOLD))
        else $error("event code out of range");

    // hold is only reported while the button is down
    a_hold_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[4:1] == EV_HOLD) |-> o_m_axis_tdata[0])
        else $error("hold reported while released");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
